// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the bounded deque.
// Each macro takes a label, a property body and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising aclk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Implication form, antecedent and consequent given apart.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication form.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bdeq_pkg.sv
`timescale 1ns / 1ps
// Package of the bounded deque: operation and status codes, fixed field widths,
// and the structs passed between the pointer control and the top level. No dependencies.
package bdeq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int WIDE_W   = 64;

    // tdata of the result: pop_value, status, entry_count, is_empty
    localparam int M_TDATA_W = 40;

    localparam logic [KIND_W-1:0] OP_PUSH_REAR  = 3'd0;
    localparam logic [KIND_W-1:0] OP_POP_FRONT  = 3'd1;
    localparam logic [KIND_W-1:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [KIND_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [KIND_W-1:0] OP_CLEAR      = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // memory access issued for one word
    typedef struct packed {
        logic we;
        logic re;
    } mem_req_t;

    // result fields known at accept time, waiting for the read data
    typedef struct packed {
        logic                is_pop;
        status_t             status;
        logic [COUNT_W-1:0]  entry_count;
        logic                is_empty;
    } res_info_t;

endpackage

// File: src/bdeq_ram.sv
`timescale 1ns / 1ps
// Single-port ring store of the bounded deque, registered read.
// Depends on nothing but its parameters.
module bdeq_ram #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic                  re,
    input  logic [AW-1:0]         addr,
    input  logic [DATA_WIDTH-1:0] wdata,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] store_mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[addr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= store_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/bdeq_ptr.sv
`timescale 1ns / 1ps
// Head pointer and occupancy of the bounded deque; decodes each word into a
// store access and the result fields. Depends on bdeq_pkg.
module bdeq_ptr #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [bdeq_pkg::KIND_W-1:0]   kind,
    output bdeq_pkg::mem_req_t            mem_req,
    output logic [AW-1:0]                 mem_addr,
    output bdeq_pkg::res_info_t           info
);

    localparam int SW = CW + 1;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] occ_reg, occ_next;

    logic [SW-1:0] rear_sum, last_sum, rear_slot, last_slot;
    logic [AW-1:0] head_inc, head_dec;
    logic          full, empty;
    bdeq_pkg::mem_req_t req;
    bdeq_pkg::status_t  status;
    logic          is_pop;

    assign full  = (occ_reg == CW'(DEPTH));
    assign empty = (occ_reg == '0);

    // slot one past the rear, and the rear itself (both below 2*DEPTH)
    assign rear_sum  = SW'(head_reg) + SW'(occ_reg);
    assign last_sum  = rear_sum - 1'b1;
    assign rear_slot = (rear_sum >= SW'(DEPTH)) ? rear_sum - SW'(DEPTH) : rear_sum;
    assign last_slot = (last_sum >= SW'(DEPTH)) ? last_sum - SW'(DEPTH) : last_sum;

    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;

    always_comb begin
        head_next = head_reg;
        occ_next  = occ_reg;
        req       = '0;
        mem_addr  = head_reg;
        status    = bdeq_pkg::ST_OK;
        is_pop    = 1'b0;
        unique case (kind)
            bdeq_pkg::OP_PUSH_REAR: begin
                if (full) begin
                    status = bdeq_pkg::ST_FULL;
                end else begin
                    req.we   = 1'b1;
                    mem_addr = rear_slot[AW-1:0];
                    occ_next = occ_reg + 1'b1;
                end
            end
            bdeq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    status = bdeq_pkg::ST_FULL;
                end else begin
                    req.we    = 1'b1;
                    mem_addr  = head_dec;
                    head_next = head_dec;
                    occ_next  = occ_reg + 1'b1;
                end
            end
            bdeq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    status = bdeq_pkg::ST_EMPTY;
                end else begin
                    req.re    = 1'b1;
                    is_pop    = 1'b1;
                    mem_addr  = head_reg;
                    head_next = head_inc;
                    occ_next  = occ_reg - 1'b1;
                end
            end
            bdeq_pkg::OP_POP_REAR: begin
                if (empty) begin
                    status = bdeq_pkg::ST_EMPTY;
                end else begin
                    req.re   = 1'b1;
                    is_pop   = 1'b1;
                    mem_addr = last_slot[AW-1:0];
                    occ_next = occ_reg - 1'b1;
                end
            end
            bdeq_pkg::OP_CLEAR: begin
                head_next = '0;
                occ_next  = '0;
            end
            default: begin
                // unused codes leave the state alone
            end
        endcase
    end

    assign mem_req.we       = req.we & accept;
    assign mem_req.re       = req.re & accept;
    assign info.is_pop      = is_pop;
    assign info.status      = status;
    assign info.entry_count = bdeq_pkg::COUNT_W'(occ_next);
    assign info.is_empty    = (occ_next == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            occ_reg  <= '0;
        end else if (accept) begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
        end
    end

endmodule

// File: src/bounded_double_ended_queue_unit.sv
`timescale 1ns / 1ps
// Bounded deque unit: an accepted word reaches m_tdata via stage 1 and the output register;
// one word accepted per cycle unless the output stalls, set by the single store port.
// Pointer and occupancy update at accept; the store read lands in the next cycle.
// Reset (aresetn low, synchronous) empties the queue and drops words in flight;
// the store contents are not cleared and no clearing pass is needed.
// Depends on bdeq_pkg, bdeq_ptr, bdeq_ram and assert_macros.svh.
`include "assert_macros.svh"

module bounded_double_ended_queue_unit #(
    parameter int DEPTH      = bdeq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdeq_pkg::DATA_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bdeq_pkg::VALUE_W-1:0]    s_tdata,   // [31:0] push_value
    input  logic [bdeq_pkg::KIND_W-1:0]     s_tuser,   // [2:0] kind

    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bdeq_pkg::M_TDATA_W-1:0]  m_tdata    // [31:0] pop_value, [33:32] status,
                                                       // [38:34] entry_count, [39] is_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // ------------------------------------------------------------------
    // Handshake: stage 1 waits on the store read, the output register
    // holds the finished word. Stage 1 drains whenever the output is free.
    // ------------------------------------------------------------------
    logic accept;
    logic out_free;

    logic                s1_valid_reg, s1_valid_next;
    bdeq_pkg::res_info_t s1_info_reg;
    logic                m_valid_reg, m_valid_next;
    logic [bdeq_pkg::M_TDATA_W-1:0] m_data_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Pointer control and ring store
    // ------------------------------------------------------------------
    bdeq_pkg::mem_req_t  mem_req;
    logic [AW-1:0]       mem_addr;
    bdeq_pkg::res_info_t info;

    logic [bdeq_pkg::WIDE_W-1:0] push_wide;
    logic [bdeq_pkg::WIDE_W-1:0] rd_wide;
    logic [DATA_WIDTH-1:0]       wdata;
    logic [DATA_WIDTH-1:0]       rdata;

    bdeq_ptr #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ptr (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .kind     (s_tuser),
        .mem_req  (mem_req),
        .mem_addr (mem_addr),
        .info     (info)
    );

    // push word is taken modulo 2^DATA_WIDTH; wide stores zero-extend it
    assign push_wide = bdeq_pkg::WIDE_W'(s_tdata);
    assign wdata     = push_wide[DATA_WIDTH-1:0];

    bdeq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .re    (mem_req.re),
        .addr  (mem_addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign rd_wide = bdeq_pkg::WIDE_W'(rdata);

    // ------------------------------------------------------------------
    // Stage 1: result fields wait here for the read data
    // ------------------------------------------------------------------
    always_comb begin
        priority if (accept) begin
            s1_valid_next = 1'b1;
        end else if (out_free) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_info_reg <= info;
        end
    end

    // ------------------------------------------------------------------
    // Output register; the store read data stays put while stage 1 waits
    // ------------------------------------------------------------------
    always_comb begin
        priority if (s1_valid_reg && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && out_free) begin
            m_data_reg <= {s1_info_reg.is_empty,
                           s1_info_reg.entry_count,
                           s1_info_reg.status,
                           s1_info_reg.is_pop ? rd_wide[bdeq_pkg::VALUE_W-1:0]
                                              : {bdeq_pkg::VALUE_W{1'b0}}};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a full pipeline with a stalled output must refuse new words
    `ASSERT_IMPL(a_stall_blocks_input, s1_valid_reg && m_valid_reg && !m_tready, !s_tready,
                 "input taken while both stages are stalled")

    // the output only fills from stage 1
    `ASSERT_NEXT(a_no_phantom_result, !s1_valid_reg && !m_valid_reg, !m_valid_reg,
                 "result word appeared with nothing in flight")

    // an error never carries read data
    `ASSERT_IMPL(a_error_no_pop, s1_valid_reg && (s1_info_reg.status != bdeq_pkg::ST_OK),
                 !s1_info_reg.is_pop, "error status flagged as pop")

endmodule
